// ===== hdl/mft_pkg.sv =====
// ----------------------------------------------------------------------------
// mft_pkg: shared types and constants for the motor feedback tracker
// Item formats, op codes, link modes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package mft_pkg;

  // item kinds
  localparam logic [1:0] OP_TICK        = 2'd0;
  localparam logic [1:0] OP_FRAME       = 2'd1;
  localparam logic [1:0] OP_COMMAND     = 2'd2;
  localparam logic [1:0] OP_RESET_TURNS = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_LIMIT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 1'd1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [14:0] CURRENT_LIMIT_RESET = 15'd16384;
  localparam logic [15:0] TIMEOUT_RESET       = 16'd5000;

  // encoder wrap bands
  localparam logic [12:0] LOW_BAND  = 13'd2048;
  localparam logic [12:0] HIGH_BAND = 13'd6144;

  localparam logic [16:0]        SILENCE_MAX = 17'h1FFFF;
  localparam logic signed [31:0] TURN_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] TURN_MIN    = 32'sh8000_0000;

  typedef enum logic [1:0] {
    MODE_DISC = 2'd0,
    MODE_IDLE = 2'd1,
    MODE_RUN  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] command_current;
    logic [12:0]        feedback_angle;
    logic signed [15:0] feedback_velocity;
    logic signed [15:0] feedback_current;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] drive_current;
    logic               link_up;
    mode_t              mode;
    logic [12:0]        angle;
    logic signed [15:0] velocity;
    logic signed [15:0] measured_current;
    logic signed [31:0] turns;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/mft_stream_if.sv =====
// ----------------------------------------------------------------------------
// mft_stream_if: valid/ready channel
// Carries one item per handshake; an item moves when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface mft_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/motor_feedback_tracker_current_limiter_core.sv =====
// ----------------------------------------------------------------------------
// motor_feedback_tracker_current_limiter_core: motor link tracker and clamp
// Tracks link state, feedback and turn count of one motor; clamps commands.
// ----------------------------------------------------------------------------
// Usage:
//   item_in carries one item per handshake: a tick, a feedback frame, a
//   current command or a turn-count reset. result_out returns exactly one
//   result per item: the tracker state after that item.
//   cfg_we/cfg_index/cfg_data write current_limit (index 0) and
//   timeout_ticks (index 1); write only while no item is in flight.
// Registers and throughput:
//   An accepted item is held in the input register, and its result is written
//   into the output register once that register is free to take it.
//   One item per cycle sustained while result_out is ready; the state update
//   for an item is combinational compare/increment logic, so back-to-back items chain cleanly.
// Reset (rst, synchronous):
//   Link down, all state zero, limit 16384, timeout 5000, both stages empty.
// Stalls:
//   While result_out is held, the pending result and one input item stay
//   registered; item_in.ready drops only when both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_feedback_tracker_current_limiter_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  mft_stream_if.sink                               item_in,
  mft_stream_if.source                             result_out,
  input  wire logic                                cfg_we,
  input  wire logic [mft_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [mft_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // configuration
  logic [14:0] current_limit;
  logic [15:0] timeout_ticks;

  // input register
  logic              in_valid;
  mft_pkg::in_item_t cur;

  // output register
  logic            out_valid;
  mft_pkg::result_t result;

  // tracker state
  mft_pkg::mode_t     link_mode, link_mode_next;
  logic signed [15:0] target_reg, target_next;
  logic [12:0]        angle_reg, angle_next;
  logic signed [15:0] velocity_reg, velocity_next;
  logic signed [15:0] current_reg, current_next;
  logic signed [31:0] turn_count, turn_next;
  logic [16:0]        silence_count, silence_next;
  logic               seen_frame, seen_next;

  logic               proc_fire;
  logic signed [16:0] cmd_ext, lim_pos, lim_neg, cmd_clamped;

  assign proc_fire     = in_valid && (!out_valid || result_out.ready);
  assign item_in.ready = !in_valid || proc_fire;

  assign result_out.valid   = out_valid;
  assign result_out.payload = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_limit <= mft_pkg::CURRENT_LIMIT_RESET;
      timeout_ticks <= mft_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mft_pkg::CFG_CURRENT_LIMIT: current_limit <= cfg_data[14:0];
        mft_pkg::CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_in.ready) begin
      in_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.ready && item_in.valid) begin
      cur <= item_in.payload;
    end
  end

  // clamp to +/- limit in 17 bits so -limit never overflows
  assign cmd_ext = {cur.command_current[15], cur.command_current};
  assign lim_pos = $signed({2'b00, current_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (cmd_ext > lim_pos) begin
      cmd_clamped = lim_pos;
    end else if (cmd_ext < lim_neg) begin
      cmd_clamped = lim_neg;
    end else begin
      cmd_clamped = cmd_ext;
    end
  end

  always_comb begin
    link_mode_next = link_mode;
    target_next    = target_reg;
    angle_next     = angle_reg;
    velocity_next  = velocity_reg;
    current_next   = current_reg;
    turn_next      = turn_count;
    silence_next   = silence_count;
    seen_next      = seen_frame;
    case (cur.op)
      mft_pkg::OP_TICK: begin
        if (silence_count != mft_pkg::SILENCE_MAX) begin
          silence_next = silence_count + 17'd1;
        end
        if (silence_next > {1'b0, timeout_ticks}) begin
          link_mode_next = mft_pkg::MODE_DISC;
        end
        if (link_mode_next == mft_pkg::MODE_DISC) begin
          target_next = '0;
        end
      end
      mft_pkg::OP_FRAME: begin
        angle_next    = cur.feedback_angle;
        velocity_next = cur.feedback_velocity;
        current_next  = cur.feedback_current;
        silence_next  = '0;
        if (link_mode == mft_pkg::MODE_DISC) begin
          link_mode_next = mft_pkg::MODE_IDLE;
        end
        // first frame only primes the previous angle
        if (!seen_frame) begin
          seen_next = 1'b1;
        end else if (cur.feedback_angle < mft_pkg::LOW_BAND &&
                     angle_reg > mft_pkg::HIGH_BAND) begin
          if (turn_count != mft_pkg::TURN_MAX) begin
            turn_next = turn_count + 32'sd1;
          end
        end else if (cur.feedback_angle > mft_pkg::HIGH_BAND &&
                     angle_reg < mft_pkg::LOW_BAND) begin
          if (turn_count != mft_pkg::TURN_MIN) begin
            turn_next = turn_count - 32'sd1;
          end
        end
      end
      mft_pkg::OP_COMMAND: begin
        if (link_mode != mft_pkg::MODE_DISC) begin
          link_mode_next = mft_pkg::MODE_RUN;
          target_next    = cmd_clamped[15:0];
        end
      end
      mft_pkg::OP_RESET_TURNS: begin
        turn_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode     <= mft_pkg::MODE_DISC;
      target_reg    <= '0;
      angle_reg     <= '0;
      velocity_reg  <= '0;
      current_reg   <= '0;
      turn_count    <= '0;
      silence_count <= '0;
      seen_frame    <= 1'b0;
    end else if (proc_fire) begin
      link_mode     <= link_mode_next;
      target_reg    <= target_next;
      angle_reg     <= angle_next;
      velocity_reg  <= velocity_next;
      current_reg   <= current_next;
      turn_count    <= turn_next;
      silence_count <= silence_next;
      seen_frame    <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      result.drive_current    <= target_next;
      result.link_up          <= (link_mode_next != mft_pkg::MODE_DISC);
      result.mode             <= link_mode_next;
      result.angle            <= angle_next;
      result.velocity         <= velocity_next;
      result.measured_current <= current_next;
      result.turns            <= turn_next;
    end
  end

  // target is always zero while the link is down
  a_disc_target_zero: assert property (@(posedge clk) disable iff (rst)
    (link_mode == mft_pkg::MODE_DISC) |-> (target_reg == 16'sd0))
    else $error("target nonzero while link down");

  // a processed frame always leaves the link up with silence cleared
  a_frame_link: assert property (@(posedge clk) disable iff (rst)
    (proc_fire && cur.op == mft_pkg::OP_FRAME) |=>
      (silence_count == 17'd0 && link_mode != mft_pkg::MODE_DISC))
    else $error("frame did not bring link up");

  // turn count moves by at most one unless explicitly reset
  a_turn_step: assert property (@(posedge clk) disable iff (rst)
    (proc_fire && cur.op != mft_pkg::OP_RESET_TURNS) |=>
      ((turn_count - $past(turn_count)) == 32'sd0 ||
       (turn_count - $past(turn_count)) == 32'sd1 ||
       (turn_count - $past(turn_count)) == -32'sd1))
    else $error("turn count jumped");

  // state only changes when an item is processed
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !proc_fire |=> ($stable(link_mode) && $stable(turn_count) &&
                    $stable(silence_count) && $stable(target_reg)))
    else $error("state changed without an item");

  // published link flag agrees with the published mode
  a_link_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result.link_up == (result.mode != mft_pkg::MODE_DISC)))
    else $error("link_up disagrees with mode");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for motor_feedback_tracker_current_limiter_core
// Directed tests for link handling, turn counting, clamping and timeouts,
// then random traffic under changing limits with random idling on both
// channels and one long output stall. An item-level tracker predicts each
// result, and every result is compared field by field in order.
// ----------------------------------------------------------------------------

module tb_top;
  import mft_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  mft_stream_if #(.payload_t(in_item_t)) item_if ();
  mft_stream_if #(.payload_t(result_t))  result_if ();

  motor_feedback_tracker_current_limiter_core dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_if),
    .result_out (result_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // tracker state as the block should hold it
  mode_t              trk_mode;
  logic signed [15:0] trk_target;
  logic [12:0]        trk_angle;
  logic signed [15:0] trk_velocity;
  logic signed [15:0] trk_current;
  logic signed [31:0] trk_turns;
  logic [16:0]        trk_silence;
  logic               trk_seen_frame;
  logic [14:0]        lim_current;
  logic [15:0]        lim_timeout;

  result_t expected_results[$];
  int      mismatches = 0;
  bit      send_idle_on = 1'b1;
  bit      recv_idle_on = 1'b1;
  int      sink_hold_cycles = 0;

  function automatic result_t advance_tracker(in_item_t it);
    result_t     r;
    logic [12:0] prev_angle;
    int          clamped;
    int          lim;
    case (it.op)
      OP_TICK: begin
        if (trk_silence != SILENCE_MAX) trk_silence++;
        if (trk_silence > {1'b0, lim_timeout}) trk_mode = MODE_DISC;
        if (trk_mode == MODE_DISC) trk_target = '0;
      end
      OP_FRAME: begin
        prev_angle     = trk_angle;
        trk_angle      = it.feedback_angle;
        trk_velocity   = it.feedback_velocity;
        trk_current    = it.feedback_current;
        trk_silence    = '0;
        if (trk_mode == MODE_DISC) trk_mode = MODE_IDLE;
        // first frame only seeds the angle
        if (!trk_seen_frame) begin
          trk_seen_frame = 1'b1;
        end else if (trk_angle < LOW_BAND && prev_angle > HIGH_BAND) begin
          if (trk_turns != TURN_MAX) trk_turns++;
        end else if (trk_angle > HIGH_BAND && prev_angle < LOW_BAND) begin
          if (trk_turns != TURN_MIN) trk_turns--;
        end
      end
      OP_COMMAND: begin
        lim     = int'(lim_current);
        clamped = int'(it.command_current);
        if (clamped > lim) clamped = lim;
        else if (clamped < -lim) clamped = -lim;
        if (trk_mode != MODE_DISC) begin
          trk_mode   = MODE_RUN;
          trk_target = 16'(clamped);
        end
      end
      OP_RESET_TURNS: begin
        trk_turns = '0;
      end
      default: ;
    endcase
    r.drive_current    = trk_target;
    r.link_up          = (trk_mode != MODE_DISC);
    r.mode             = trk_mode;
    r.angle            = trk_angle;
    r.velocity         = trk_velocity;
    r.measured_current = trk_current;
    r.turns            = trk_turns;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      got = result_if.payload;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, turns", got.turns, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.drive_current !== want.drive_current)
          report_mismatch("drive_current", got.drive_current, want.drive_current);
        if (got.link_up !== want.link_up)
          report_mismatch("link_up", got.link_up, want.link_up);
        if (got.mode !== want.mode)
          report_mismatch("mode", got.mode, want.mode);
        if (got.angle !== want.angle)
          report_mismatch("angle", got.angle, want.angle);
        if (got.velocity !== want.velocity)
          report_mismatch("velocity", got.velocity, want.velocity);
        if (got.measured_current !== want.measured_current)
          report_mismatch("measured_current", got.measured_current,
                          want.measured_current);
        if (got.turns !== want.turns)
          report_mismatch("turns", got.turns, want.turns);
      end
    end
  end

  // result receiver: random stalls, plus a long hold on request
  initial begin : result_sink
    int stall;
    result_if.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        result_if.ready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk);
        sink_hold_cycles = 0;
      end
      stall = recv_idle_on ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
    end
  end

  // valid is left high after an accept; settle() or the next gap lowers it
  task automatic send_item(in_item_t it);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.valid   <= 1'b1;
    item_if.payload <= it;
    do @(posedge clk); while (!item_if.ready);
    expected_results.push_back(advance_tracker(it));
  endtask

  task automatic settle();
    item_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (index)
      CFG_CURRENT_LIMIT: lim_current = data[14:0];
      CFG_TIMEOUT_TICKS: lim_timeout = data;
      default: ;
    endcase
  endtask

  // random content in every field, op forced
  function automatic in_item_t noise_item(logic [1:0] op);
    logic [63:0] raw;
    in_item_t    it;
    raw   = {$urandom, $urandom};
    it    = raw[$bits(in_item_t)-1:0];
    it.op = op;
    return it;
  endfunction

  task automatic send_op(logic [1:0] op);
    send_item(noise_item(op));
  endtask

  task automatic send_frame(logic [12:0] ang, logic signed [15:0] vel,
                            logic signed [15:0] cur);
    in_item_t it;
    it                   = noise_item(OP_FRAME);
    it.feedback_angle    = ang;
    it.feedback_velocity = vel;
    it.feedback_current  = cur;
    send_item(it);
  endtask

  task automatic send_command(logic signed [15:0] cur);
    in_item_t it;
    it                 = noise_item(OP_COMMAND);
    it.command_current = cur;
    send_item(it);
  endtask

  function automatic in_item_t random_item(int tick_pct);
    in_item_t it;
    int       pick;
    int       c;
    pick = $urandom_range(0, 99);
    if (pick < tick_pct) it = noise_item(OP_TICK);
    else if (pick < tick_pct + (100 - tick_pct) * 45 / 100) it = noise_item(OP_FRAME);
    else if (pick < 93) it = noise_item(OP_COMMAND);
    else it = noise_item(OP_RESET_TURNS);
    if (it.op == OP_FRAME) begin
      // lean on the wrap bands so turns move often
      case ($urandom_range(0, 4))
        0: it.feedback_angle = 13'($urandom_range(0, 2047));
        1: it.feedback_angle = 13'($urandom_range(6145, 8191));
        2: case ($urandom_range(0, 3))
             0: it.feedback_angle = LOW_BAND - 13'd1;
             1: it.feedback_angle = LOW_BAND;
             2: it.feedback_angle = HIGH_BAND;
             default: it.feedback_angle = HIGH_BAND + 13'd1;
           endcase
        default: ;
      endcase
    end
    if (it.op == OP_COMMAND && $urandom_range(0, 2) == 0) begin
      c = int'(lim_current) - 1 + int'($urandom_range(0, 2));
      if ($urandom_range(0, 1) == 1) c = -c;
      it.command_current = 16'(c);
    end
    return it;
  endfunction

  task automatic test_disconnected_link();
    // before any frame: command is dropped, tick keeps the link down
    send_command(16'sd32767);
    send_op(OP_TICK);
  endtask

  task automatic test_turn_counting();
    send_frame(13'd8191, -16'sd32768, 16'sd32767);  // first frame, no turn
    send_frame(13'd0, 16'sd32767, -16'sd32768);     // wrap up
    send_frame(13'd8191, 16'sd0, 16'sd0);           // wrap down
    send_frame(LOW_BAND - 13'd1, 16'sd1, -16'sd1);  // wrap up at band edge
    send_frame(HIGH_BAND + 13'd1, -16'sd1, 16'sd1); // wrap down at band edge
    send_frame(LOW_BAND, 16'sd5, 16'sd5);           // band edges themselves: no wrap
    send_frame(HIGH_BAND, 16'sd6, 16'sd6);
    send_op(OP_RESET_TURNS);
  endtask

  task automatic test_current_clamp();
    send_command(16'sd32767);
    send_command(-16'sd32768);
    send_command(-16'sd16385);
    settle();
    write_reg(CFG_CURRENT_LIMIT, 16'd0);
    send_command(16'sd12345);
    settle();
    write_reg(CFG_CURRENT_LIMIT, 16'd1);
    send_command(-16'sd2);
    settle();
    write_reg(CFG_CURRENT_LIMIT, 16'd16384);
  endtask

  task automatic test_link_timeout();
    settle();
    write_reg(CFG_TIMEOUT_TICKS, 16'd0);
    send_op(OP_TICK);           // single tick drops the link
    send_command(16'sd100);     // ignored while down
    settle();
    write_reg(CFG_TIMEOUT_TICKS, 16'd3);
    send_frame(13'd100, 16'sd10, 16'sd20);
    send_command(16'sd500);
    repeat (4) send_op(OP_TICK); // fourth tick drops link, zeroes target
    settle();
    write_reg(CFG_TIMEOUT_TICKS, 16'hFFFF);
    send_op(OP_TICK);
    settle();
  endtask

  task automatic test_output_backpressure();
    settle();
    send_idle_on     = 1'b0;
    sink_hold_cycles = 60;
    repeat (20) send_item(random_item(50));
    settle();
    send_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [14:0] lim_sel;
    logic [15:0] tmo_sel;
    int          tick_pct;
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      if (phase == 0) begin
        lim_sel = '0;
        tmo_sel = '0;
      end else if (phase == 1) begin
        lim_sel = 15'd16384;
        tmo_sel = 16'hFFFF;
      end else begin
        case ($urandom_range(0, 3))
          0: lim_sel = '0;
          1: lim_sel = 15'd16384;
          default: lim_sel = 15'($urandom_range(0, 16384));
        endcase
        case ($urandom_range(0, 4))
          0: tmo_sel = '0;
          1: tmo_sel = 16'hFFFF;
          2: tmo_sel = 16'($urandom_range(1, 5000));
          default: tmo_sel = 16'($urandom_range(1, 40));
        endcase
      end
      write_reg(CFG_CURRENT_LIMIT, {1'b0, lim_sel});
      write_reg(CFG_TIMEOUT_TICKS, tmo_sel);
      case ($urandom_range(0, 2))
        0: tick_pct = 25;
        1: tick_pct = 50;
        default: tick_pct = 75;
      endcase
      send_idle_on = ($urandom_range(0, 2) != 0);
      recv_idle_on = ($urandom_range(0, 2) != 0);
      repeat (200) send_item(random_item(tick_pct));
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  initial begin
    item_if.valid   = 1'b0;
    item_if.payload = '0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    trk_mode        = MODE_DISC;
    trk_target      = '0;
    trk_angle       = '0;
    trk_velocity    = '0;
    trk_current     = '0;
    trk_turns       = '0;
    trk_silence     = '0;
    trk_seen_frame  = 1'b0;
    lim_current     = CURRENT_LIMIT_RESET;
    lim_timeout     = TIMEOUT_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_disconnected_link();
    test_turn_counting();
    test_current_clamp();
    test_link_timeout();
    test_output_backpressure();
    test_random_traffic();
    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mft_pkg.sv
hdl/mft_stream_if.sv
hdl/motor_feedback_tracker_current_limiter_core.sv
tb/sv/tb_top.sv
